// File: sv/cd_pkg.sv
// Shared types and constants for the circular deque.
`default_nettype none
package cd_pkg;

  localparam int unsigned DepthDefault     = 16;
  localparam int unsigned DataWidthDefault = 32;
  localparam int unsigned IoWidth          = 32;

  typedef enum logic [1:0] {
    ACT_PUSH_FRONT = 2'd0,
    ACT_PUSH_REAR  = 2'd1,
    ACT_POP_FRONT  = 2'd2,
    ACT_POP_REAR   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic push_front;
    logic push_rear;
    logic pop_front;
    logic pop_rear;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } dp_flags_t;

endpackage
`default_nettype wire

// File: sv/cd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module cd_ram #(
  parameter int unsigned WIDTH = cd_pkg::DataWidthDefault,
  parameter int unsigned DEPTH = cd_pkg::DepthDefault
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// File: sv/cd_ctrl.sv
// Deque controller: request decode, rejection, result strobe and status.
`default_nettype none
module cd_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [1:0]        action_i,
  input  wire cd_pkg::dp_flags_t flags_i,
  output cd_pkg::dp_cmd_t        cmd_o,
  output logic                   done_o,
  output logic [1:0]             status_o
);

  logic              accept;
  logic              done_q;
  cd_pkg::status_e   status_d;
  cd_pkg::status_e   status_q;
  cd_pkg::action_e   act;

  assign busy   = 1'b0;
  assign accept = start & ~busy;
  assign act    = cd_pkg::action_e'(action_i);

  always_comb begin
    cmd_o    = '0;
    status_d = cd_pkg::ST_DONE;
    if (accept) begin
      unique case (act)
        cd_pkg::ACT_PUSH_FRONT: begin
          if (flags_i.full) status_d = cd_pkg::ST_FULL;
          else cmd_o.push_front = 1'b1;
        end
        cd_pkg::ACT_PUSH_REAR: begin
          if (flags_i.full) status_d = cd_pkg::ST_FULL;
          else cmd_o.push_rear = 1'b1;
        end
        cd_pkg::ACT_POP_FRONT: begin
          if (flags_i.empty) status_d = cd_pkg::ST_EMPTY;
          else cmd_o.pop_front = 1'b1;
        end
        cd_pkg::ACT_POP_REAR: begin
          if (flags_i.empty) status_d = cd_pkg::ST_EMPTY;
          else cmd_o.pop_rear = 1'b1;
        end
        default: status_d = cd_pkg::ST_DONE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q   <= 1'b0;
      status_q <= cd_pkg::ST_DONE;
    end else begin
      done_q <= accept;
      if (accept) status_q <= status_d;
    end
  end

  assign done_o   = done_q;
  assign status_o = status_q;

endmodule
`default_nettype wire

// File: sv/cd_dp.sv
// Deque datapath: front and rear pointers, empty flag and ring store.
`default_nettype none
module cd_dp #(
  parameter int unsigned DEPTH      = cd_pkg::DepthDefault,
  parameter int unsigned DATA_WIDTH = cd_pkg::DataWidthDefault
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire cd_pkg::dp_cmd_t            cmd_i,
  input  wire logic signed [cd_pkg::IoWidth-1:0] data_in_i,
  output cd_pkg::dp_flags_t               flags_o,
  output logic signed [cd_pkg::IoWidth-1:0] data_out_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam logic [AW-1:0] LastPos = AW'(DEPTH - 1);

  function automatic logic [AW-1:0] next_pos(input logic [AW-1:0] p);
    next_pos = (p == LastPos) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [AW-1:0] prev_pos(input logic [AW-1:0] p);
    prev_pos = (p == '0) ? LastPos : p - 1'b1;
  endfunction

  logic [AW-1:0]         head_q, head_d;
  logic [AW-1:0]         tail_q, tail_d;
  logic                  empty_q, empty_d;
  logic                  pop_q;
  logic                  push;
  logic                  pop;
  logic [AW-1:0]         wslot;
  logic [AW-1:0]         rslot;
  logic [63:0]           din_wide;
  logic [63:0]           dout_wide;
  logic [DATA_WIDTH-1:0] rdata;

  assign push     = cmd_i.push_front | cmd_i.push_rear;
  assign pop      = cmd_i.pop_front | cmd_i.pop_rear;
  assign din_wide = 64'($unsigned(data_in_i));
  assign rslot    = cmd_i.pop_front ? head_q : tail_q;

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    empty_d = empty_q;
    wslot   = '0;
    if (push) begin
      empty_d = 1'b0;
      if (empty_q) begin
        head_d = '0;
        tail_d = '0;
      end else if (cmd_i.push_front) begin
        head_d = prev_pos(head_q);
        wslot  = head_d;
      end else begin
        tail_d = next_pos(tail_q);
        wslot  = tail_d;
      end
    end else if (pop) begin
      if (head_q == tail_q) empty_d = 1'b1;
      else if (cmd_i.pop_front) head_d = next_pos(head_q);
      else tail_d = prev_pos(tail_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      empty_q <= 1'b1;
      pop_q   <= 1'b0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      empty_q <= empty_d;
      pop_q   <= pop;
    end
  end

  cd_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (push),
    .waddr_i (wslot),
    .wdata_i (din_wide[DATA_WIDTH-1:0]),
    .re_i    (pop),
    .raddr_i (rslot),
    .rdata_o (rdata)
  );

  assign dout_wide     = 64'(rdata);
  assign data_out_o    = pop_q ? $signed(dout_wide[cd_pkg::IoWidth-1:0]) : '0;
  assign flags_o.empty = empty_q;
  assign flags_o.full  = ~empty_q & (next_pos(tail_q) == head_q);

endmodule
`default_nettype wire

// File: sv/circular_deque.sv
// Circular deque top level: controller plus pointer/ring-store datapath.
// Latency: the result beat appears on done_o the cycle after a request is taken.
// Throughput: one request per cycle; busy stays low, as the pointers are updated on each
// request and the ring RAM has one write and one read port (pops use its registered read).
// Reset: deque empty, pointers at zero; the ring RAM is not cleared.
// The receiver cannot stall: each result is valid for exactly one cycle.
`default_nettype none
module circular_deque #(
  parameter int unsigned DEPTH      = cd_pkg::DepthDefault,
  parameter int unsigned DATA_WIDTH = cd_pkg::DataWidthDefault
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [1:0]                        action_i,
  input  wire logic signed [cd_pkg::IoWidth-1:0] data_in_i,
  output logic                                   done_o,
  output logic signed [cd_pkg::IoWidth-1:0]      data_out_o,
  output logic [1:0]                             status_o,
  output logic                                   is_empty_o,
  output logic                                   is_full_o
);

  cd_pkg::dp_cmd_t   cmd;
  cd_pkg::dp_flags_t flags;

  cd_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .action_i (action_i),
    .flags_i  (flags),
    .cmd_o    (cmd),
    .done_o   (done_o),
    .status_o (status_o)
  );

  cd_dp #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .data_in_i  (data_in_i),
    .flags_o    (flags),
    .data_out_o (data_out_o)
  );

  assign is_empty_o = flags.empty;
  assign is_full_o  = flags.full;

endmodule
`default_nettype wire
